### rtl/tle_pkg.sv
// Shared types and character constants for the terminal line editor.
package tle_pkg;

  localparam int unsigned BUFFER_LEN_DEFAULT = 64;
  localparam int unsigned QUEUE_DEPTH        = 2;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef enum logic [1:0] {
    OP_LINE_END,
    OP_ERASE,
    OP_CHAR
  } tle_op_e;

  typedef struct packed {
    tle_op_e    op;
    logic [7:0] data;
    logic       echo;
  } tle_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LINE_RD,
    ST_LINE_OUT,
    ST_TERM,
    ST_ECHO
  } tle_state_e;

endpackage

### rtl/terminal_line_editor.sv
// Top level of the terminal line editor: front, command queue and back.
//
// Received bytes enter on in_valid_i/in_ready_o (in_byte_i); every result
// leaves on out_valid_o/out_ready_i as out_kind_o, out_byte_o and out_last_o,
// where out_last_o marks the final result of a received byte. The echo flag
// is written on cfg_valid_i/cfg_ready_o (cfg_echo_enable_i); the user must
// do so only while idle, which the block itself does not enforce. The front
// classifies each byte into a command and pushes it into a two-entry queue;
// in_ready_o stays high while that queue has room. The back takes one
// command at a time from the queue, taking the next only once idle again:
//   byte or erase: one result per echo byte (up to 5), none with echo off;
//   line end: each stored character is read through the registered read
//   port of the line store and then output, followed by a NUL terminator.
// Results pass through a single output register; when the receiver stalls
// the back holds, the queue fills and in_ready_o drops.
// Reset clears the fill count, the echo flag, the queue and the output
// register; the line store holds no reset value and is read only below the
// fill count.
module terminal_line_editor #(
  parameter int unsigned BUFFER_LEN = tle_pkg::BUFFER_LEN_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_echo_enable_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       out_kind_o,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);
  import tle_pkg::*;

  logic     push;
  tle_cmd_t push_cmd;
  logic     q_full;
  logic     q_valid;
  logic     q_pop;
  tle_cmd_t q_cmd;

  tle_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .in_byte_i         (in_byte_i),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_echo_enable_i (cfg_echo_enable_i),
    .push_o            (push),
    .cmd_o             (push_cmd),
    .q_full_i          (q_full)
  );

  tle_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .pop_cmd_o  (q_cmd)
  );

  tle_back #(
    .BUFFER_LEN (BUFFER_LEN)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_cmd_i     (q_cmd),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_kind_o  (out_kind_o),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o)
  );

endmodule

### rtl/tle_front.sv
// Input side: echo register, byte classification and command push.
module tle_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        in_byte_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_echo_enable_i,
  output logic              push_o,
  output tle_pkg::tle_cmd_t cmd_o,
  input  logic              q_full_i
);
  import tle_pkg::*;

  logic echo_q;
  logic echo_d;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !q_full_i;
  assign push_o      = in_valid_i && !q_full_i;

  always_comb begin
    echo_d = echo_q;
    if (cfg_valid_i) begin
      echo_d = cfg_echo_enable_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      echo_q <= 1'b0;
    end else begin
      echo_q <= echo_d;
    end
  end

  always_comb begin
    cmd_o.data = in_byte_i;
    cmd_o.echo = echo_q;
    if (in_byte_i == CH_CR || in_byte_i == CH_LF) begin
      cmd_o.op = OP_LINE_END;
    end else if (in_byte_i == CH_BS || in_byte_i == CH_DEL) begin
      cmd_o.op = OP_ERASE;
    end else begin
      cmd_o.op = OP_CHAR;
    end
  end

endmodule

### rtl/tle_queue.sv
// Short command queue between the front and the back.
module tle_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  tle_pkg::tle_cmd_t push_cmd_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output tle_pkg::tle_cmd_t pop_cmd_o
);
  import tle_pkg::*;

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned NW = $clog2(QUEUE_DEPTH + 1);

  tle_cmd_t        slot_q [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [NW-1:0]   count_q, count_d;
  logic            do_push, do_pop;

  assign full_o    = (count_q == NW'(QUEUE_DEPTH));
  assign valid_o   = (count_q != '0);
  assign pop_cmd_o = slot_q[rd_ptr_q];
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

### rtl/tle_back.sv
// Execution side: line store, fill count, sequencer and output register.
module tle_back #(
  parameter int unsigned BUFFER_LEN = tle_pkg::BUFFER_LEN_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  tle_pkg::tle_cmd_t q_cmd_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              out_kind_o,
  output logic [7:0]        out_byte_o,
  output logic              out_last_o
);
  import tle_pkg::*;

  localparam int unsigned DEPTH = BUFFER_LEN - 1;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = $clog2(BUFFER_LEN);
  localparam logic [CW-1:0] CAP = CW'(DEPTH);

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    hex_char = (v < 4'd10) ? (8'h30 + {4'h0, v}) : (8'h37 + {4'h0, v});
  endfunction

  logic [7:0]    mem [DEPTH];
  logic [7:0]    rd_data_q;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;

  tle_state_e    state_q, state_d;
  tle_cmd_t      cmd_q, cmd_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [CW-1:0] idx_q, idx_d;
  logic          full_q, full_d;
  logic [2:0]    step_q, step_d;
  logic [2:0]    len_q, len_d;

  logic          out_valid_q, out_valid_d;
  logic          out_kind_q, out_kind_d;
  logic [7:0]    out_byte_q, out_byte_d;
  logic          out_last_q, out_last_d;

  logic          slot_free;
  logic          in_full;
  logic          in_print;
  logic          echo_last;
  logic [CW-1:0] idx_next;
  logic [2:0]    sub_step;
  logic [7:0]    echo_byte;

  assign slot_free = !out_valid_q || out_ready_i;
  assign in_full   = (fill_q == CAP);
  assign in_print  = (q_cmd_i.data >= CH_SPACE) && (q_cmd_i.data <= CH_TILDE);
  assign echo_last = (step_q == len_q - 3'd1);
  assign idx_next  = idx_q + 1'b1;
  assign sub_step  = step_q - {2'b00, full_q};

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

  always_comb begin
    if (cmd_q.op == OP_ERASE) begin
      echo_byte = (step_q == 3'd1) ? CH_SPACE : CH_BS;
    end else if (full_q && step_q == 3'd0) begin
      echo_byte = CH_BS;
    end else if (cmd_q.data >= CH_SPACE && cmd_q.data <= CH_TILDE) begin
      echo_byte = cmd_q.data;
    end else begin
      case (sub_step)
        3'd0:    echo_byte = CH_LT;
        3'd1:    echo_byte = hex_char(cmd_q.data[7:4]);
        3'd2:    echo_byte = hex_char(cmd_q.data[3:0]);
        default: echo_byte = CH_GT;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          case (q_cmd_i.op)
            OP_LINE_END: state_d = (fill_q == '0) ? ST_TERM : ST_LINE_RD;
            OP_ERASE:    state_d = (fill_q != '0 && q_cmd_i.echo) ? ST_ECHO : ST_IDLE;
            default:     state_d = q_cmd_i.echo ? ST_ECHO : ST_IDLE;
          endcase
        end
      end
      ST_LINE_RD: state_d = ST_LINE_OUT;
      ST_LINE_OUT: begin
        if (slot_free) begin
          state_d = (idx_next == fill_q) ? ST_TERM : ST_LINE_RD;
        end
      end
      ST_TERM: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_ECHO: begin
        if (slot_free && echo_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    q_pop_o     = 1'b0;
    cmd_d       = cmd_q;
    fill_d      = fill_q;
    idx_d       = idx_q;
    full_d      = full_q;
    step_d      = step_q;
    len_d       = len_q;
    rd_en       = 1'b0;
    rd_addr     = idx_q[AW-1:0];
    wr_en       = 1'b0;
    wr_addr     = fill_q[AW-1:0];
    out_valid_d = out_valid_q && !out_ready_i;
    out_kind_d  = out_kind_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cmd_d   = q_cmd_i;
          idx_d   = '0;
          step_d  = '0;
          case (q_cmd_i.op)
            OP_LINE_END: begin
              idx_d = '0;
            end
            OP_ERASE: begin
              len_d = 3'd3;
              if (fill_q != '0) begin
                fill_d = fill_q - 1'b1;
              end
            end
            default: begin
              wr_en  = 1'b1;
              full_d = in_full;
              if (in_full) begin
                wr_addr = AW'(fill_q - 1'b1);
              end else begin
                fill_d = fill_q + 1'b1;
              end
              len_d = {2'b00, in_full} + (in_print ? 3'd1 : 3'd4);
            end
          endcase
        end
      end
      ST_LINE_RD: begin
        rd_en = 1'b1;
      end
      ST_LINE_OUT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = 1'b1;
          out_byte_d  = rd_data_q;
          out_last_d  = 1'b0;
          idx_d       = idx_next;
        end
      end
      ST_TERM: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = 1'b1;
          out_byte_d  = CH_NUL;
          out_last_d  = 1'b1;
          fill_d      = '0;
        end
      end
      ST_ECHO: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = 1'b0;
          out_byte_d  = echo_byte;
          out_last_d  = echo_last;
          step_d      = step_q + 3'd1;
        end
      end
      default: begin
        q_pop_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    idx_q      <= idx_d;
    full_q     <= full_d;
    step_q     <= step_d;
    len_q      <= len_d;
    out_kind_q <= out_kind_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= cmd_d.data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the terminal line editor: directed table, then random lines.
module tb_top;
  import tle_pkg::*;

  localparam int unsigned LINE_CAP      = BUFFER_LEN_DEFAULT - 1;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT   = 2000000;
  localparam logic        KIND_ECHO     = 1'b0;
  localparam logic        KIND_LINE     = 1'b1;

  typedef enum logic {
    ROW_BYTE,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [7:0]  value;
    logic        typed;
    logic [2:0]  n_res;
    logic        res_kind;
    logic [31:0] res_bytes;
  } plan_row_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       last;
  } term_res_t;

  localparam plan_row_t PLAN [22] = '{
    '{ROW_BYTE, CH_CR,    1'b1, 3'd1, KIND_LINE, 32'(CH_NUL)},
    '{ROW_BYTE, CH_BS,    1'b1, 3'd0, KIND_ECHO, 32'h0},
    '{ROW_BYTE, CH_DEL,   1'b1, 3'd0, KIND_ECHO, 32'h0},
    '{ROW_BYTE, "A",      1'b1, 3'd0, KIND_ECHO, 32'h0},
    '{ROW_BYTE, 8'h00,    1'b1, 3'd0, KIND_ECHO, 32'h0},
    '{ROW_BYTE, 8'hFF,    1'b1, 3'd0, KIND_ECHO, 32'h0},
    '{ROW_BYTE, CH_BS,    1'b1, 3'd0, KIND_ECHO, 32'h0},
    '{ROW_BYTE, CH_LF,    1'b0, 3'd0, KIND_ECHO, 32'h0},
    '{ROW_CFG,  8'h01,    1'b0, 3'd0, KIND_ECHO, 32'h0},
    '{ROW_BYTE, CH_SPACE, 1'b1, 3'd1, KIND_ECHO, 32'(CH_SPACE)},
    '{ROW_BYTE, CH_TILDE, 1'b1, 3'd1, KIND_ECHO, 32'(CH_TILDE)},
    '{ROW_BYTE, 8'h1F,    1'b1, 3'd4, KIND_ECHO, "<1F>"},
    '{ROW_BYTE, 8'h80,    1'b1, 3'd4, KIND_ECHO, "<80>"},
    '{ROW_BYTE, 8'hFF,    1'b1, 3'd4, KIND_ECHO, "<FF>"},
    '{ROW_BYTE, 8'h00,    1'b1, 3'd4, KIND_ECHO, "<00>"},
    '{ROW_BYTE, CH_DEL,   1'b1, 3'd3, KIND_ECHO, 32'({CH_BS, CH_SPACE, CH_BS})},
    '{ROW_BYTE, CH_BS,    1'b1, 3'd3, KIND_ECHO, 32'({CH_BS, CH_SPACE, CH_BS})},
    '{ROW_BYTE, CH_CR,    1'b0, 3'd0, KIND_ECHO, 32'h0},
    '{ROW_BYTE, CH_BS,    1'b1, 3'd0, KIND_ECHO, 32'h0},
    '{ROW_BYTE, "z",      1'b1, 3'd1, KIND_ECHO, 32'("z")},
    '{ROW_BYTE, CH_LF,    1'b0, 3'd0, KIND_ECHO, 32'h0},
    '{ROW_CFG,  8'h00,    1'b0, 3'd0, KIND_ECHO, 32'h0}
  };

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] in_byte_i;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic       cfg_echo_enable_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic       out_kind_o;
  logic [7:0] out_byte_o;
  logic       out_last_o;

  logic [7:0] shadow_line [64];
  logic [5:0] shadow_fill = '0;
  logic       shadow_echo = 1'b0;
  term_res_t  model_q [$];
  term_res_t  pending_out_q [$];

  bit calm = 1'b0;
  int n_cycles = 0;
  int n_errors = 0;
  int n_bytes_in = 0;
  int n_results = 0;
  int n_lines = 0;
  int n_overwrites = 0;

  terminal_line_editor uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .in_byte_i         (in_byte_i),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_echo_enable_i (cfg_echo_enable_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .out_kind_o        (out_kind_o),
    .out_byte_o        (out_byte_o),
    .out_last_o        (out_last_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
  end

  initial begin
    wait (n_cycles >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results outstanding", n_cycles,
             pending_out_q.size());
    $display("** terminal_line_editor: FAILED **");
    $finish;
  end

  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    n_errors++;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    return (v < 4'd10) ? 8'("0") + 8'(v) : 8'("A") + 8'(v) - 8'd10;
  endfunction

  function automatic void add_result(input logic kind, input logic [7:0] data);
    model_q.push_back('{kind, data, 1'b0});
  endfunction

  // Apply one received byte to the shadow line state; results land in model_q.
  function automatic void edit_line(input logic [7:0] b);
    term_res_t tail;
    model_q.delete();
    if (b == CH_CR || b == CH_LF) begin
      for (int i = 0; i < int'(shadow_fill); i++) add_result(KIND_LINE, shadow_line[i]);
      add_result(KIND_LINE, CH_NUL);
      shadow_fill = '0;
      n_lines++;
    end else if (b == CH_BS || b == CH_DEL) begin
      if (shadow_fill != 0) begin
        shadow_fill = shadow_fill - 6'd1;
        if (shadow_echo) begin
          add_result(KIND_ECHO, CH_BS);
          add_result(KIND_ECHO, CH_SPACE);
          add_result(KIND_ECHO, CH_BS);
        end
      end
    end else begin
      if (shadow_fill < LINE_CAP) begin
        shadow_line[shadow_fill] = b;
        shadow_fill = shadow_fill + 6'd1;
      end else begin
        shadow_line[shadow_fill - 6'd1] = b;
        n_overwrites++;
        if (shadow_echo) add_result(KIND_ECHO, CH_BS);
      end
      if (shadow_echo) begin
        if (b >= CH_SPACE && b <= CH_TILDE) begin
          add_result(KIND_ECHO, b);
        end else begin
          add_result(KIND_ECHO, CH_LT);
          add_result(KIND_ECHO, hex_char(b[7:4]));
          add_result(KIND_ECHO, hex_char(b[3:0]));
          add_result(KIND_ECHO, CH_GT);
        end
      end
    end
    if (model_q.size() != 0) begin
      tail = model_q.pop_back();
      tail.last = 1'b1;
      model_q.push_back(tail);
    end
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic typed, input logic [2:0] n_res,
                           input logic res_kind, input logic [31:0] res_bytes);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    do @(negedge clk_i); while (!in_ready_o);
    edit_line(b);
    if (typed) begin
      for (int i = 0; i < int'(n_res); i++)
        pending_out_q.push_back('{res_kind, res_bytes[8*(int'(n_res)-1-i) +: 8],
                                  i == int'(n_res) - 1});
    end else begin
      foreach (model_q[i]) pending_out_q.push_back(model_q[i]);
    end
    n_bytes_in++;
    @(posedge clk_i);
  endtask

  task automatic feed(input logic [7:0] b);
    push_byte(b, 1'b0, 3'd0, KIND_ECHO, 32'h0);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_out_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_echo(input logic v);
    drain_results();
    cfg_valid_i       <= 1'b1;
    cfg_echo_enable_i <= v;
    do @(negedge clk_i); while (!cfg_ready_o);
    shadow_echo = v;
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  always @(negedge clk_i) begin
    term_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_results++;
      if (pending_out_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected result kind %0d byte %02h last %0d",
                                out_kind_o, out_byte_o, out_last_o));
      end else begin
        want = pending_out_q.pop_front();
        if (out_kind_o !== want.kind)
          flag_mismatch($sformatf("out_kind %0d, want %0d", out_kind_o, want.kind));
        if (out_byte_o !== want.data)
          flag_mismatch($sformatf("out_byte %02h, want %02h", out_byte_o, want.data));
        if (out_last_o !== want.last)
          flag_mismatch($sformatf("out_last %0d, want %0d", out_last_o, want.last));
      end
    end
  end

  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      out_ready_i <= 1'b1;
      if (calm) begin
        @(posedge clk_i);
      end else begin
        repeat ($urandom_range(1, 40)) @(posedge clk_i);
        if (!calm && $urandom_range(0, 2) != 0) begin
          out_ready_i <= 1'b0;
          repeat ($urandom_range(1, 18)) @(posedge clk_i);
        end
      end
    end
  end

  initial begin
    int         n_phase;
    int         len;
    int         pick;
    bit         long_due;
    logic [7:0] b;

    rst_ni            = 1'b0;
    in_valid_i        = 1'b0;
    in_byte_i         = '0;
    cfg_valid_i       = 1'b0;
    cfg_echo_enable_i = 1'b0;
    foreach (shadow_line[i]) shadow_line[i] = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (PLAN[k]) begin
      if (PLAN[k].kind == ROW_CFG)
        write_echo(PLAN[k].value[0]);
      else
        push_byte(PLAN[k].value, PLAN[k].typed, PLAN[k].n_res, PLAN[k].res_kind,
                  PLAN[k].res_bytes);
    end

    for (int ph = 0; ph < 5; ph++) begin
      if (ph == 4) calm = 1'b1;
      write_echo(ph[0]);
      n_phase  = 0;
      long_due = (ph == 0 || ph == 3);
      while (n_phase < 10) begin
        if (!long_due && $urandom_range(0, 9) == 0) begin
          feed(8'($urandom_range(0, 255)));
          n_phase++;
        end else begin
          len = long_due ? $urandom_range(64, 67) : $urandom_range(0, 12);
          for (int j = 0; j < len; j++) begin
            pick = long_due ? $urandom_range(2, 15) : $urandom_range(0, 15);
            if (pick < 2) begin
              b = pick[0] ? CH_BS : CH_DEL;
            end else if (pick < 4) begin
              b = 8'($urandom_range(0, 255));
              if (b == CH_CR || b == CH_LF || b == CH_BS || b == CH_DEL) b = b ^ 8'h80;
            end else begin
              b = 8'($urandom_range(CH_SPACE, CH_TILDE));
            end
            feed(b);
            n_phase++;
          end
          long_due = 1'b0;
          feed($urandom_range(0, 1) ? CH_CR : CH_LF);
          n_phase++;
        end
      end
    end

    drain_results();
    $display("covered %0d received bytes, %0d results checked, %0d lines released",
             n_bytes_in, n_results, n_lines);
    $display("echo on and off, %0d overwrites at full store, %0d mismatches",
             n_overwrites, n_errors);
    if (n_errors == 0 && pending_out_q.size() == 0) begin
      $display("** terminal_line_editor: PASSED **");
    end else begin
      $display("** terminal_line_editor: FAILED **");
    end
    $finish;
  end

endmodule
